[design/shell_word_escaper_assert.svh]
// Assertion macros for the shell word escaper.
`ifndef SHELL_WORD_ESCAPER_ASSERT_SVH
`define SHELL_WORD_ESCAPER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define SEW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition implies a consequence on the next edge.
`define SEW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define SEW_ASSERT(lbl, clk, rst_n, prop, msg)
`define SEW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[design/sew_pkg.sv]
`timescale 1ns / 1ps

package sew_pkg;

    // How a queued byte gets expanded by the back end.
    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_BSLASH = 2'd1,
        KIND_HEX    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_CMD_NAME = 2'd1,
        MODE_CMD_PART = 2'd2,
        MODE_CMD_ARG  = 2'd3
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    localparam int unsigned HEX_LEN = 7;
    localparam int unsigned STEP_W  = 3;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

[design/sew_in_if.sv]
`timescale 1ns / 1ps

interface sew_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_first;

    modport source (output valid, output in_byte, output is_first, input ready);
    modport sink   (input valid, input in_byte, input is_first, output ready);
endinterface

[design/sew_out_if.sv]
`timescale 1ns / 1ps

interface sew_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[design/sew_front.sv]
`timescale 1ns / 1ps

module sew_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sew_in_if.sink        i_in_ch,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data,
    output logic          o_push,
    output sew_pkg::t_item o_push_item,
    input  logic          i_push_ready
);

    sew_pkg::t_mode r_mode;
    logic           is_ctrl;
    logic           is_meta;
    logic           is_brace;
    logic           is_lead;
    logic [7:0]     b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sew_pkg::MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= sew_pkg::t_mode'(i_cfg_data);
        end
    end

    assign b = i_in_ch.in_byte;

    always_comb begin
        is_ctrl  = (b < sew_pkg::CH_SPACE) || (b == sew_pkg::CH_DEL);
        is_meta  = (b == 8'h20) || (b == 8'h5c) || (b == 8'h3b) || (b == 8'h27) ||
                   (b == 8'h22) || (b == 8'h60) || (b == 8'h7c) || (b == 8'h26) ||
                   (b == 8'h3c) || (b == 8'h3e) || (b == 8'h28) || (b == 8'h29) ||
                   (b == 8'h24) || (b == 8'h23) || (b == 8'h7e);
        is_brace = (b == 8'h7b) || (b == 8'h7d);
        is_lead  = ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2b) || (b == 8'h2d) ||
                   (b == 8'h5b) || (b == 8'h5d);

        o_push_item.data = b;
        if (r_mode == sew_pkg::MODE_NONE) begin
            o_push_item.kind = sew_pkg::KIND_PLAIN;
        end else if (r_mode == sew_pkg::MODE_CMD_NAME && i_in_ch.is_first && is_lead) begin
            o_push_item.kind = sew_pkg::KIND_BSLASH;
        end else if (is_ctrl) begin
            o_push_item.kind = sew_pkg::KIND_HEX;
        end else if (is_meta || (is_brace && (r_mode == sew_pkg::MODE_CMD_NAME ||
                                              r_mode == sew_pkg::MODE_CMD_PART))) begin
            o_push_item.kind = sew_pkg::KIND_BSLASH;
        end else begin
            o_push_item.kind = sew_pkg::KIND_PLAIN;
        end
    end

    assign i_in_ch.ready = i_push_ready;
    assign o_push        = i_in_ch.valid && i_push_ready;

endmodule

[design/sew_fifo.sv]
`timescale 1ns / 1ps

`include "shell_word_escaper_assert.svh"

module sew_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sew_pkg::t_item i_push_item,
    output logic           o_push_ready,
    input  logic           i_pop,
    output logic           o_head_valid,
    output sew_pkg::t_item o_head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sew_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `SEW_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count overflow")
    `SEW_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && r_count == '0), "pop from empty queue")
    `SEW_ASSERT_NEXT(a_push_only_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not grow on push")

endmodule

[design/sew_back.sv]
`timescale 1ns / 1ps

`include "shell_word_escaper_assert.svh"

module sew_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  sew_pkg::t_item i_head_item,
    output logic           o_pop,
    sew_out_if.source      o_out_ch
);

    localparam logic [sew_pkg::STEP_W-1:0] HEX_LAST = sew_pkg::STEP_W'(sew_pkg::HEX_LEN - 1);

    logic [sew_pkg::STEP_W-1:0] r_step;
    logic [sew_pkg::STEP_W-1:0] n_step;
    logic                       r_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;
    logic                       load;
    logic [7:0]                 cur_byte;
    logic                       cur_last;

    // Pick the byte for the current step of the head entry.
    always_comb begin
        cur_byte = i_head_item.data;
        cur_last = 1'b1;
        case (i_head_item.kind)
            sew_pkg::KIND_PLAIN: begin
                cur_byte = i_head_item.data;
                cur_last = 1'b1;
            end
            sew_pkg::KIND_BSLASH: begin
                cur_last = (r_step != '0);
                cur_byte = (r_step == '0) ? sew_pkg::CH_BSLASH : i_head_item.data;
            end
            sew_pkg::KIND_HEX: begin
                cur_last = (r_step == HEX_LAST);
                case (r_step)
                    3'd0:    cur_byte = sew_pkg::CH_DOLLAR;
                    3'd1:    cur_byte = sew_pkg::CH_QUOTE;
                    3'd2:    cur_byte = sew_pkg::CH_BSLASH;
                    3'd3:    cur_byte = sew_pkg::CH_X;
                    3'd4:    cur_byte = sew_pkg::hex_char(i_head_item.data[7:4]);
                    3'd5:    cur_byte = sew_pkg::hex_char(i_head_item.data[3:0]);
                    default: cur_byte = sew_pkg::CH_QUOTE;
                endcase
            end
            default: begin
                cur_byte = i_head_item.data;
                cur_last = 1'b1;
            end
        endcase
    end

    assign load  = i_head_valid && (!r_valid || o_out_ch.ready);
    assign o_pop = load && cur_last;

    always_comb begin
        n_step = r_step;
        if (load) begin
            n_step = cur_last ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
        end
    end

    assign o_out_ch.valid       = r_valid;
    assign o_out_ch.out_byte    = r_byte;
    assign o_out_ch.last_of_run = r_last;

    `SEW_ASSERT(a_step_range, i_clk, i_rst_n, r_step <= HEX_LAST, "step counter out of range")
    `SEW_ASSERT(a_step_has_head, i_clk, i_rst_n, r_step == '0 || i_head_valid, "mid-run with empty queue")
    `SEW_ASSERT(a_plain_no_step, i_clk, i_rst_n, r_step == '0 || i_head_item.kind != sew_pkg::KIND_PLAIN, "plain entry mid-run")
    `SEW_ASSERT_NEXT(a_pop_sets_last, i_clk, i_rst_n, o_pop, r_valid && r_last, "pop without last word")

endmodule

[design/shell_word_escaper.sv]
`timescale 1ns / 1ps

// Accepted bytes pass through the queue; the back-end step sequencer then fills
// the output register, one word per cycle while the output is ready and the
// queue is not empty; 1, 2 or 7 words per byte (plain, backslash, $'\xHH' form).
// The queue between front and back holds QUEUE_DEPTH classified bytes.
// Reset (synchronous, active low): mode 0, queue empty, output invalid.
module shell_word_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sew_in_if.sink     i_in_ch,
    sew_out_if.source  o_out_ch,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    logic           push;
    logic           push_ready;
    logic           pop;
    logic           head_valid;
    sew_pkg::t_item push_item;
    sew_pkg::t_item head_item;

    sew_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    sew_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_item  (head_item)
    );

    sew_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_item  (head_item),
        .o_pop        (pop),
        .o_out_ch     (o_out_ch)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BYTES = 18;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_esc_word;

    // characters that take a backslash in every mode except MODE_NONE
    localparam logic [7:0] SHELL_META [15] = '{
        8'h20, 8'h5c, 8'h3b, 8'h27, 8'h22, 8'h60, 8'h7c, 8'h26,
        8'h3c, 8'h3e, 8'h28, 8'h29, 8'h24, 8'h23, 8'h7e
    };
    localparam logic [7:0] LEAD_SIGNS [4] = '{8'h2b, 8'h2d, 8'h5b, 8'h5d};
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    class escape_tracker;
        t_esc_word   expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [7:0] nibble_char(logic [3:0] n);
            return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
        endfunction

        // expected escaped words for one accepted input byte
        function void note_byte(logic [7:0] b, logic first, sew_pkg::t_mode mode);
            logic meta;
            logic lead;
            meta = 1'b0;
            foreach (SHELL_META[i]) begin
                if (b == SHELL_META[i]) meta = 1'b1;
            end
            if ((b == CH_LBRACE || b == CH_RBRACE) &&
                (mode == sew_pkg::MODE_CMD_NAME || mode == sew_pkg::MODE_CMD_PART)) begin
                meta = 1'b1;
            end
            lead = (b >= 8'h30 && b <= 8'h39);
            foreach (LEAD_SIGNS[i]) begin
                if (b == LEAD_SIGNS[i]) lead = 1'b1;
            end

            if (mode == sew_pkg::MODE_NONE) begin
                expected_q.push_back('{b, 1'b1});
            end else if (mode == sew_pkg::MODE_CMD_NAME && first && lead) begin
                expected_q.push_back('{sew_pkg::CH_BSLASH, 1'b0});
                expected_q.push_back('{b, 1'b1});
            end else if (b < sew_pkg::CH_SPACE || b == sew_pkg::CH_DEL) begin
                expected_q.push_back('{sew_pkg::CH_DOLLAR, 1'b0});
                expected_q.push_back('{sew_pkg::CH_QUOTE, 1'b0});
                expected_q.push_back('{sew_pkg::CH_BSLASH, 1'b0});
                expected_q.push_back('{sew_pkg::CH_X, 1'b0});
                expected_q.push_back('{nibble_char(b[7:4]), 1'b0});
                expected_q.push_back('{nibble_char(b[3:0]), 1'b0});
                expected_q.push_back('{sew_pkg::CH_QUOTE, 1'b1});
            end else if (meta) begin
                expected_q.push_back('{sew_pkg::CH_BSLASH, 1'b0});
                expected_q.push_back('{b, 1'b1});
            end else begin
                expected_q.push_back('{b, 1'b1});
            end
        endfunction

        function void check_word(logic [7:0] data, logic last);
            t_esc_word want;
            if (expected_q.size() == 0) begin
                $error("out_byte: no word expected, got %h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data) begin
                $error("out_byte: expected %h, got %h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_data;
    sew_pkg::t_mode cur_mode;
    logic           calm;
    int unsigned    stall_left;
    int unsigned    cycle_count;

    escape_tracker tracker = new();

    sew_in_if  in_ch();
    sew_out_if out_ch();

    shell_word_escaper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // output side: random stall bursts, always ready once calm
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL shell_word_escaper");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_word(out_ch.out_byte, out_ch.last_of_run);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.in_byte  = b;
        in_ch.is_first = first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_byte(b, first, cur_mode);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_mode(input sew_pkg::t_mode m);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cur_mode = m;
    endtask

    function automatic logic [7:0] pick_byte(input logic first);
        int unsigned r;
        logic [7:0]  b;
        r = first ? $urandom_range(0, 6) : $urandom_range(0, 4);
        case (r)
            0: begin
                b = 8'($urandom_range(0, 255));
            end
            1: begin
                b = SHELL_META[$urandom_range(0, 14)];
                if ($urandom_range(0, 4) == 0) b = $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE;
            end
            2: begin
                b = ($urandom_range(0, 7) == 0) ? sew_pkg::CH_DEL : 8'($urandom_range(0, 31));
            end
            3: begin
                b = 8'($urandom_range(128, 255));
            end
            default: begin
                // digits and the signs that matter at the start of a command name
                r = $urandom_range(0, 13);
                b = (r < 10) ? 8'h30 + 8'(r) : LEAD_SIGNS[r - 10];
            end
        endcase
        return b;
    endfunction

    task automatic run_phase(input sew_pkg::t_mode m);
        int unsigned sent;
        int unsigned len;
        logic [7:0]  b;
        set_mode(m);
        sent = 0;
        while (sent < PHASE_BYTES) begin
            len = $urandom_range(1, 8);
            for (int unsigned i = 0; i < len; i++) begin
                b = pick_byte(i == 0);
                send_byte(b, i == 0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = sew_pkg::MODE_NONE;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.is_first = 1'b0;
        out_ch.ready   = 1'b0;
        cur_mode       = sew_pkg::MODE_NONE;
        calm           = 1'b0;
        stall_left     = 0;
        cycle_count    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // pass-through mode straight out of reset
        send_byte(8'h00, 1'b1);
        send_byte(8'h5c, 1'b0);
        send_byte(8'hff, 1'b0);

        set_mode(sew_pkg::MODE_CMD_NAME);
        send_byte(8'h30, 1'b1);
        send_byte(8'h39, 1'b0);
        send_byte(8'h2b, 1'b1);
        send_byte(8'h2d, 1'b1);
        send_byte(8'h5b, 1'b1);
        send_byte(8'h5d, 1'b1);
        send_byte(8'h61, 1'b1);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1f, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7e, 1'b0);
        send_byte(8'h24, 1'b0);

        set_mode(sew_pkg::MODE_CMD_PART);
        send_byte(8'h2d, 1'b1);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(8'h0a, 1'b0);

        set_mode(sew_pkg::MODE_CMD_ARG);
        send_byte(8'h35, 1'b1);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(8'h3b, 1'b0);

        run_phase(sew_pkg::MODE_CMD_ARG);
        run_phase(sew_pkg::MODE_NONE);
        run_phase(sew_pkg::MODE_CMD_NAME);
        run_phase(sew_pkg::MODE_CMD_PART);
        run_phase(sew_pkg::t_mode'($urandom_range(0, 3)));
        run_phase(sew_pkg::t_mode'($urandom_range(0, 3)));
        calm = 1'b1;
        run_phase(sew_pkg::MODE_CMD_NAME);

        drain();
        repeat (10) @(negedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS shell_word_escaper");
        end else begin
            $display("FAIL shell_word_escaper");
        end
        $finish;
    end

endmodule
